// File: rtl/core/wpi_pkg.sv
// shared types, constants and register codes of the windowed peak interpolator
package wpi_pkg;

  localparam int DEFAULT_MAX_SAMPLES = 2048;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  // widths fixed by the register and field formats
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IDX_W      = 12;
  localparam int BND_W      = 29;
  localparam int BND_NUM_W  = 29;
  localparam int BND_DEN_W  = 17;
  localparam int DIST_NUM_W = 39;
  localparam int DIV_NUM_W  = 38;
  localparam int DIV_DEN_W  = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_FROM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TO   = 3'd4;

  localparam logic [15:0] RST_FRAME_START = 16'd0;
  localparam logic [15:0] RST_FRAME_END   = 16'd10000;
  localparam logic [11:0] RST_SAMPLES     = 12'd1535;
  localparam logic [15:0] RST_SEARCH_FROM = 16'd700;
  localparam logic [15:0] RST_SEARCH_TO   = 16'd2000;

  typedef struct packed {
    logic signed [15:0] power_sample;
    logic               last_in_frame;
  } sample_t;

  typedef struct packed {
    logic               found;
    logic signed [11:0] peak_index;
    logic [15:0]        peak_distance_mm;
    logic signed [15:0] peak_power;
  } result_t;

  typedef struct packed {
    logic [15:0] frame_start_mm;
    logic [15:0] frame_end_mm;
    logic [11:0] sample_count;
    logic [15:0] search_from_mm;
    logic [15:0] search_to_mm;
  } cfg_t;

  typedef struct packed {
    logic                    busy;
    logic                    span_ok;
    logic signed [BND_W-1:0] low;
    logic signed [BND_W-1:0] high;
  } bnd_t;

  // one finished frame handed from the front to the back
  typedef struct packed {
    logic               ok;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
  } frame_t;

endpackage

// File: rtl/core/wpi_div.sv
// serial restoring divider, one quotient bit per cycle
module wpi_div #(
  parameter int NW = 29,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [NW-1:0]    quo;
  logic [DW-1:0]    dvs;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             fits;

  assign shifted = {rem, quo[NW-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};
  assign quot    = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (cnt != '0) begin
      quo <= {quo[NW-2:0], fits};
      rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

endmodule

// File: rtl/core/wpi_bounds.sv
// configuration registers and search window bounds in sample indices
module wpi_bounds (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wpi_pkg::CFG_DATA_W-1:0] cfg_data,
  output wpi_pkg::cfg_t                 cfg,
  output wpi_pkg::bnd_t                 bnd
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_MUL   = 2'd1;
  localparam logic [1:0] B_START = 2'd2;
  localparam logic [1:0] B_WAIT  = 2'd3;

  localparam int BW = wpi_pkg::BND_W;

  logic [1:0]           state;
  logic                 sel;
  logic [27:0]          prod;
  logic                 neg;
  logic signed [BW-1:0] low;
  logic signed [BW-1:0] high;

  logic [15:0]          d_sel;
  logic signed [16:0]   d_diff;
  logic signed [16:0]   d_negv;
  logic [15:0]          d_mag;
  logic signed [16:0]   e_diff;
  logic signed [16:0]   e_negv;
  logic [15:0]          e_mag;
  logic                 div_start;
  logic                 div_done;
  logic [wpi_pkg::BND_NUM_W-1:0] div_num;
  logic [wpi_pkg::BND_DEN_W-1:0] div_den;
  logic [wpi_pkg::BND_NUM_W-1:0] div_quot;
  logic signed [BW-1:0] q_pos;
  logic signed [BW-1:0] q_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_start_mm <= wpi_pkg::RST_FRAME_START;
      cfg.frame_end_mm   <= wpi_pkg::RST_FRAME_END;
      cfg.sample_count   <= wpi_pkg::RST_SAMPLES;
      cfg.search_from_mm <= wpi_pkg::RST_SEARCH_FROM;
      cfg.search_to_mm   <= wpi_pkg::RST_SEARCH_TO;
    end else if (cfg_we) begin
      case (cfg_index)
        wpi_pkg::CFG_FRAME_START: cfg.frame_start_mm <= cfg_data;
        wpi_pkg::CFG_FRAME_END:   cfg.frame_end_mm   <= cfg_data;
        wpi_pkg::CFG_SAMPLES:     cfg.sample_count   <= cfg_data[11:0];
        wpi_pkg::CFG_SEARCH_FROM: cfg.search_from_mm <= cfg_data;
        wpi_pkg::CFG_SEARCH_TO:   cfg.search_to_mm   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign d_sel  = sel ? cfg.search_to_mm : cfg.search_from_mm;
  assign d_diff = $signed({1'b0, d_sel}) - $signed({1'b0, cfg.frame_start_mm});
  assign d_negv = -d_diff;
  assign d_mag  = d_diff[16] ? d_negv[15:0] : d_diff[15:0];
  assign e_diff = $signed({1'b0, cfg.frame_end_mm}) - $signed({1'b0, cfg.frame_start_mm});
  assign e_negv = -e_diff;
  assign e_mag  = e_diff[16] ? e_negv[15:0] : e_diff[15:0];

  // round half away from zero: (2|num| + |den|) / (2|den|)
  assign div_start = state == B_START;
  assign div_num   = {prod, 1'b0} + wpi_pkg::BND_NUM_W'(e_mag);
  assign div_den   = {e_mag, 1'b0};
  assign q_pos     = $signed({1'b0, div_quot[27:0]});
  assign q_val     = neg ? -q_pos : q_pos;

  wpi_div #(
    .NW(wpi_pkg::BND_NUM_W),
    .DW(wpi_pkg::BND_DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_MUL;
      sel   <= 1'b0;
    end else if (cfg_we) begin
      state <= B_MUL;
      sel   <= 1'b0;
    end else begin
      case (state)
        B_MUL:   state <= B_START;
        B_START: state <= B_WAIT;
        B_WAIT: begin
          if (div_done) begin
            sel   <= 1'b1;
            state <= sel ? B_IDLE : B_MUL;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_MUL) begin
      prod <= cfg.sample_count * d_mag;
      neg  <= d_diff[16] ^ e_diff[16];
    end
    if (state == B_WAIT && div_done) begin
      if (sel) begin
        high <= q_val;
      end else begin
        low <= q_val;
      end
    end
  end

  assign bnd.busy    = state != B_IDLE;
  assign bnd.span_ok = cfg.frame_start_mm != cfg.frame_end_mm;
  assign bnd.low     = low;
  assign bnd.high    = high;

endmodule

// File: rtl/core/wpi_front.sv
// per-sample peak tracking over one frame
module wpi_front #(
  parameter int MAX_SAMPLES = wpi_pkg::DEFAULT_MAX_SAMPLES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  wpi_pkg::sample_t sample,
  input  wpi_pkg::cfg_t    cfg,
  input  wpi_pkg::bnd_t    bnd,
  output logic             rec_write,
  output wpi_pkg::frame_t  rec
);

  localparam int POS_W = $clog2(MAX_SAMPLES + 1);
  localparam int BP_W  = $clog2(MAX_SAMPLES);
  localparam int BW    = wpi_pkg::BND_W;

  logic [POS_W-1:0]     sample_position;
  logic signed [15:0]   best_power;
  logic [BP_W-1:0]      best_position;
  logic signed [15:0]   before_best;
  logic signed [15:0]   after_best;
  logic signed [15:0]   previous_sample;
  logic                 awaiting_after;

  logic signed [15:0]   best_power_next;
  logic [BP_W-1:0]      best_position_next;
  logic signed [15:0]   before_best_next;
  logic signed [15:0]   after_best_next;
  logic                 awaiting_after_next;

  logic signed [15:0]   x;
  logic                 in_range;
  logic signed [BW-1:0] pos_s;
  logic signed [BW-1:0] bpos_s;
  logic signed [BW-1:0] n_m1;
  logic signed [BW-1:0] max_s;
  logic                 found_pre;

  assign x        = sample.power_sample;
  assign in_range = sample_position < POS_W'(MAX_SAMPLES);
  assign pos_s    = $signed(BW'(sample_position));
  assign n_m1     = $signed(BW'(cfg.sample_count)) - $signed(BW'(1));
  assign max_s    = $signed(BW'(MAX_SAMPLES));

  always_comb begin
    best_power_next     = best_power;
    best_position_next  = best_position;
    before_best_next    = before_best;
    after_best_next     = after_best;
    awaiting_after_next = awaiting_after;
    if (in_range) begin
      if (awaiting_after &&
          sample_position == POS_W'(best_position) + POS_W'(1)) begin
        after_best_next     = x;
        awaiting_after_next = 1'b0;
      end
      if (bnd.span_ok && pos_s == bnd.low) begin
        best_power_next     = x;
        best_position_next  = sample_position[BP_W-1:0];
        before_best_next    = previous_sample;
        awaiting_after_next = 1'b0;
      end else if (bnd.span_ok && pos_s > bnd.low && pos_s <= bnd.high &&
                   x > best_power) begin
        best_power_next     = x;
        best_position_next  = sample_position[BP_W-1:0];
        before_best_next    = previous_sample;
        awaiting_after_next = 1'b1;
      end
    end
  end

  assign bpos_s    = $signed(BW'(best_position_next));
  assign found_pre = bnd.span_ok && bnd.low > $signed(BW'(0)) && bnd.high < n_m1 &&
                     bnd.high < max_s && pos_s >= bnd.high && !awaiting_after_next &&
                     bpos_s > bnd.low && bpos_s < bnd.high &&
                     best_power_next > before_best_next &&
                     best_power_next > after_best_next;

  assign rec_write = accept && sample.last_in_frame;
  assign rec.ok    = found_pre;
  assign rec.idx   = wpi_pkg::IDX_W'(best_position_next);
  assign rec.a     = before_best_next;
  assign rec.b     = best_power_next;
  assign rec.c     = after_best_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      best_power      <= '0;
      best_position   <= '0;
      before_best     <= '0;
      after_best      <= '0;
      previous_sample <= '0;
      awaiting_after  <= 1'b0;
    end else if (accept) begin
      if (sample.last_in_frame) begin
        sample_position <= '0;
        best_power      <= '0;
        best_position   <= '0;
        before_best     <= '0;
        after_best      <= '0;
        previous_sample <= '0;
        awaiting_after  <= 1'b0;
      end else begin
        if (in_range) begin
          sample_position <= sample_position + POS_W'(1);
        end
        best_power      <= best_power_next;
        best_position   <= best_position_next;
        before_best     <= before_best_next;
        after_best      <= after_best_next;
        previous_sample <= x;
        awaiting_after  <= awaiting_after_next;
      end
    end
  end

endmodule

// File: rtl/core/wpi_queue.sv
// short frame queue between tracking and interpolation
module wpi_queue #(
  parameter int DEPTH = wpi_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            write,
  input  wpi_pkg::frame_t wdata,
  output logic            full,
  input  logic            read,
  output wpi_pkg::frame_t rdata,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wpi_pkg::frame_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign do_wr = write && !full;
  assign do_rd = read && !empty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/core/wpi_back.sv
// parabolic interpolation of one frame and the result register
module wpi_back (
  input  logic             clk,
  input  logic             rst,
  input  wpi_pkg::cfg_t    cfg,
  input  logic             rec_empty,
  input  wpi_pkg::frame_t  rec,
  output logic             rec_read,
  input  logic             pop,
  output logic             empty,
  output wpi_pkg::result_t result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DELTA = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_DIST  = 3'd5;
  localparam logic [2:0] S_DWAIT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int NUM_W = wpi_pkg::DIST_NUM_W;
  localparam int DNW   = wpi_pkg::DIV_NUM_W;
  localparam int DDW   = wpi_pkg::DIV_DEN_W;

  logic [2:0]                 state;
  logic signed [15:0]         a;
  logic signed [15:0]         b;
  logic signed [15:0]         c;
  logic [wpi_pkg::IDX_W-1:0]  idx;
  logic signed [15:0]         power;
  logic [27:0]                sn;
  logic signed [20:0]         posq;
  logic signed [NUM_W-2:0]    prod;
  logic signed [NUM_W-1:0]    num;
  wpi_pkg::result_t           pend;
  logic                       out_valid;

  logic signed [16:0]         diff_ac;
  logic signed [16:0]         diff_negv;
  logic [15:0]                ac_mag;
  logic                       delta_neg;
  logic signed [18:0]         curv;
  logic signed [18:0]         psum;
  logic signed [18:0]         padj;
  logic signed [18:0]         pw;
  logic signed [16:0]         es;
  logic signed [8:0]          dq;
  logic signed [8:0]          delta;
  logic                       div_start;
  logic                       div_done;
  logic [DNW-1:0]             div_num;
  logic [DDW-1:0]             div_den;
  logic [DNW-1:0]             div_quot;
  logic [15:0]                dist_sat;
  logic                       out_free;

  assign diff_ac   = 17'(a) - 17'(c);
  assign diff_negv = -diff_ac;
  assign ac_mag    = diff_ac[16] ? diff_negv[15:0] : diff_ac[15:0];
  assign delta_neg = !diff_ac[16] && diff_ac != 17'sd0;
  assign curv      = 19'(b) + 19'(b) - 19'(a) - 19'(c);
  assign psum      = 19'(a) + 19'(b) + 19'(b) + 19'(c);
  assign padj      = psum[18] ? psum + 19'sd3 : psum;
  assign pw        = padj >>> 2;
  assign es        = $signed({1'b0, cfg.frame_end_mm}) - $signed({1'b0, cfg.frame_start_mm});
  assign dq        = $signed({1'b0, div_quot[7:0]});
  assign delta     = delta_neg ? -dq : dq;
  assign dist_sat  = (|div_quot[DNW-1:16]) ? 16'hFFFF : div_quot[15:0];

  assign div_start = (state == S_PREP) || (state == S_DIST && !num[NUM_W-1]);
  assign div_num   = (state == S_PREP) ? DNW'({ac_mag, 7'b0}) : num[DNW-1:0];
  assign div_den   = (state == S_PREP) ? DDW'(curv[17:0]) : {cfg.sample_count, 8'b0};

  wpi_div #(
    .NW(DNW),
    .DW(DDW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign rec_read = state == S_IDLE && !rec_empty;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!rec_empty) begin
            state <= rec.ok ? S_PREP : S_OUT;
          end
        end
        S_PREP:  state <= S_DELTA;
        S_DELTA: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL:   state <= S_SUM;
        S_SUM:   state <= S_DIST;
        S_DIST:  state <= num[NUM_W-1] ? S_OUT : S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        a   <= rec.a;
        b   <= rec.b;
        c   <= rec.c;
        idx <= rec.idx;
        pend.found            <= 1'b0;
        pend.peak_index       <= -12'sd1;
        pend.peak_distance_mm <= '0;
        pend.peak_power       <= '0;
      end
      S_PREP: begin
        power <= pw[15:0];
        sn    <= cfg.frame_start_mm * cfg.sample_count;
      end
      S_DELTA: begin
        posq <= $signed({1'b0, idx, 8'b0}) + 21'(delta);
      end
      S_MUL: begin
        prod <= (NUM_W-1)'(posq) * (NUM_W-1)'(es);
      end
      S_SUM: begin
        num <= $signed({3'b0, sn, 8'b0}) + NUM_W'(prod);
      end
      S_DIST: begin
        pend.found            <= 1'b1;
        pend.peak_index       <= $signed(idx);
        pend.peak_distance_mm <= '0;
        pend.peak_power       <= power;
      end
      S_DWAIT: begin
        if (div_done) begin
          pend.peak_distance_mm <= dist_sat;
        end
      end
      S_OUT: begin
        if (out_free) begin
          result <= pend;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/windowed_peak_interpolator.sv
// top level of the windowed peak interpolator
//
// sample channel: an item is one power sample (signed q8.8 db) and a last flag;
// it is taken on a clock edge with push high and full low, one per cycle.
// result channel: one item per frame, on the sample marked last; it is shown
// while empty is low and leaves on a clock edge with pop high.
// configuration: cfg_we, cfg_index and cfg_data write one register per cycle.
// after reset and after every configuration write the window bounds are
// recomputed by a serial divider while full stays high.
// tracking handles each sample as it is taken. a finished frame goes into a
// two-entry queue; the back end runs two serial divisions on a frame with a
// peak (interpolation offset and, unless its numerator is negative, distance)
// and none on a frame without.
// a stalled receiver holds the result register; the back end then waits, the
// queue fills and full stays high while it holds two frames.
// reset is synchronous; it clears the tracking state, the queue and the result
// valid flag and loads the configuration registers with their defaults.
module windowed_peak_interpolator #(
  parameter int MAX_SAMPLES = wpi_pkg::DEFAULT_MAX_SAMPLES,
  parameter int QUEUE_DEPTH = wpi_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  wpi_pkg::sample_t               sample,
  output logic                           empty,
  input  logic                           pop,
  output wpi_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [wpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpi_pkg::CFG_DATA_W-1:0] cfg_data
);

  wpi_pkg::cfg_t   cfg;
  wpi_pkg::bnd_t   bnd;
  wpi_pkg::frame_t rec_in;
  wpi_pkg::frame_t rec_out;
  logic            accept;
  logic            rec_write;
  logic            rec_read;
  logic            q_full;
  logic            q_empty;

  assign full   = bnd.busy || q_full;
  assign accept = push && !full;

  wpi_bounds u_bounds (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .bnd      (bnd)
  );

  wpi_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .sample   (sample),
    .cfg      (cfg),
    .bnd      (bnd),
    .rec_write(rec_write),
    .rec      (rec_in)
  );

  wpi_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .write(rec_write),
    .wdata(rec_in),
    .full (q_full),
    .read (rec_read),
    .rdata(rec_out),
    .empty(q_empty)
  );

  wpi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rec_empty(q_empty),
    .rec      (rec_out),
    .rec_read (rec_read),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

  a_cfg_stalls: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> full)
    else $error("input not stalled after a register write");

  a_not_found_fields: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.found |-> result.peak_index == -12'sd1 &&
      result.peak_distance_mm == 16'd0 && result.peak_power == 16'sd0)
    else $error("not-found item carries non-default fields");

  a_empty_after_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(empty) |-> $past(pop))
    else $error("result item dropped without a pop");

endmodule

// File: tb/tb_windowed_peak_interpolator.sv
// self-checking testbench of the windowed peak interpolator: directed, far-window, back-pressure and random frames
`timescale 1ns / 1ps

module tb_windowed_peak_interpolator;
  import wpi_pkg::*;

  localparam int MAX_SAMPLES = DEFAULT_MAX_SAMPLES;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 720;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_PLATEAU,
    SHAPE_BOUNDARY,
    SHAPE_SHORT,
    SHAPE_NOISE
  } frame_shape_e;

  logic clk;
  logic rst;
  logic push;
  logic full;
  sample_t sample;
  logic empty;
  logic pop;
  result_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // register copies
  logic [15:0] reg_start;
  logic [15:0] reg_end;
  logic [11:0] reg_n;
  logic [15:0] reg_from;
  logic [15:0] reg_to;

  // peak tracking state
  logic [11:0] trk_pos;
  logic [11:0] trk_best_pos;
  logic signed [15:0] trk_best;
  logic signed [15:0] trk_before;
  logic signed [15:0] trk_after;
  logic signed [15:0] trk_prev;
  bit trk_wait_after;

  result_t pending_results[$];
  sample_t frame_buf[$];

  int errors = 0;
  int send_gap_max = 0;
  int recv_gap_max = 0;
  int hold_cycles = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int peaks_seen = 0;
  int results_seen = 0;
  int settings_count = 0;
  int stall_cycles = 0;
  int random_items = 0;
  int cycle_count = 0;

  windowed_peak_interpolator u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    bit neg;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return neg ? -q : q;
  endfunction

  function automatic longint bound_of(logic [15:0] d);
    longint n;
    longint s;
    longint e;
    longint dl;
    n = reg_n;
    s = reg_start;
    e = reg_end;
    dl = d;
    return round_div(n * (dl - s), e - s);
  endfunction

  function automatic void clear_tracking();
    trk_pos = '0;
    trk_best_pos = '0;
    trk_best = '0;
    trk_before = '0;
    trk_after = '0;
    trk_prev = '0;
    trk_wait_after = 1'b0;
  endfunction

  // expected result of one accepted sample, queued on the last one of a frame
  function automatic void predict_sample(sample_t s);
    logic signed [15:0] x;
    bit span_ok;
    bit ok;
    longint lo, hi, pos, n, st, en, a, b, c, den, delta, posq, dist_mm, pw;
    result_t r;
    x = s.power_sample;
    span_ok = reg_start != reg_end;
    lo = 0;
    hi = 0;
    pos = trk_pos;
    n = reg_n;
    st = reg_start;
    en = reg_end;
    if (span_ok) begin
      lo = bound_of(reg_from);
      hi = bound_of(reg_to);
    end
    if (trk_pos < MAX_SAMPLES) begin
      if (trk_wait_after && trk_pos == trk_best_pos + 1) begin
        trk_after = x;
        trk_wait_after = 1'b0;
      end
      if (span_ok && pos == lo) begin
        trk_best = x;
        trk_best_pos = trk_pos;
        trk_before = trk_prev;
        trk_wait_after = 1'b0;
      end else if (span_ok && pos > lo && pos <= hi && x > trk_best) begin
        trk_best = x;
        trk_best_pos = trk_pos;
        trk_before = trk_prev;
        trk_wait_after = 1'b1;
      end
    end
    if (!s.last_in_frame) begin
      if (trk_pos < MAX_SAMPLES) trk_pos = trk_pos + 1;
      trk_prev = x;
      return;
    end
    ok = span_ok && lo > 0 && hi < n - 1 && hi < MAX_SAMPLES && pos >= hi &&
         !trk_wait_after && longint'(trk_best_pos) > lo && longint'(trk_best_pos) < hi &&
         trk_best > trk_before && trk_best > trk_after;
    if (ok) begin
      a = trk_before;
      b = trk_best;
      c = trk_after;
      den = a - 2 * b + c;
      delta = (128 * (a - c)) / den;
      posq = 256 * longint'(trk_best_pos) + delta;
      dist_mm = (st * 256 * n + posq * (en - st)) / (256 * n);
      pw = (a + 2 * b + c) / 4;
      if (dist_mm < 0) dist_mm = 0;
      if (dist_mm > 65535) dist_mm = 65535;
      r.found = 1'b1;
      r.peak_index = trk_best_pos;
      r.peak_distance_mm = dist_mm[15:0];
      r.peak_power = pw[15:0];
    end else begin
      r.found = 1'b0;
      r.peak_index = -12'sd1;
      r.peak_distance_mm = '0;
      r.peak_power = '0;
    end
    pending_results.push_back(r);
    clear_tracking();
  endfunction

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 18;
    endcase
  endfunction

  task automatic send_item(sample_t s);
    int gap;
    @(negedge clk);
    push <= 1'b1;
    sample <= s;
    do begin
      @(posedge clk);
      if (full) stall_cycles++;
    end while (full);
    predict_sample(s);
    items_sent++;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  task automatic send_frame();
    sample_t s;
    for (int i = 0; i < frame_buf.size(); i++) begin
      s = frame_buf[i];
      s.last_in_frame = (i == frame_buf.size() - 1);
      send_item(s);
    end
    frames_sent++;
  endtask

  function automatic void add_sample(int v);
    sample_t s;
    s.power_sample = v[15:0];
    s.last_in_frame = 1'b0;
    frame_buf.push_back(s);
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_START: reg_start = data;
      CFG_FRAME_END:   reg_end = data;
      CFG_SAMPLES:     reg_n = data[11:0];
      CFG_SEARCH_FROM: reg_from = data;
      CFG_SEARCH_TO:   reg_to = data;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [15:0] st, input logic [15:0] en,
                            input logic [15:0] cnt, input logic [15:0] from_mm,
                            input logic [15:0] to_mm);
    wait_idle();
    write_reg(CFG_FRAME_START, st);
    write_reg(CFG_FRAME_END, en);
    write_reg(CFG_SAMPLES, cnt);
    write_reg(CFG_SEARCH_FROM, from_mm);
    write_reg(CFG_SEARCH_TO, to_mm);
    settings_count++;
  endtask

  // frame shaped around the current search window
  task automatic build_frame(frame_shape_e shape, int max_hi, int extra);
    longint lo, hi;
    int len, p, peak;
    frame_buf.delete();
    lo = 0;
    hi = 0;
    if (reg_start != reg_end) begin
      lo = bound_of(reg_from);
      hi = bound_of(reg_to);
    end
    if (!(lo > 0 && hi - lo >= 2 && hi < max_hi)) shape = SHAPE_NOISE;
    if (shape == SHAPE_NOISE) begin
      len = $urandom_range(1, 40);
      repeat (len) add_sample(int'($urandom));
      return;
    end
    len = int'(hi) + 1 + extra;
    if (shape == SHAPE_SHORT) len = $urandom_range(1, int'(hi));
    p = $urandom_range(int'(lo) + 1, int'(hi) - 1);
    if (shape == SHAPE_BOUNDARY) p = $urandom_range(0, 1) ? int'(lo) : int'(hi);
    peak = rand_in(10001, 32767);
    for (int i = 0; i < len; i++) begin
      if (i == p || (shape == SHAPE_PLATEAU && i == p + 1)) add_sample(peak);
      else add_sample(rand_in(-20000, 10000));
    end
  endtask

  task automatic test_directed();
    // reset settings, frame ends before the far edge
    frame_buf.delete();
    add_sample(0);
    add_sample(32767);
    send_frame();
    // window 1..3 over six samples
    set_window(16'd0, 16'd600, 16'd6, 16'd100, 16'd300);
    frame_buf.delete();
    add_sample(-32768);
    add_sample(-32768);
    add_sample(32767);
    add_sample(-32768);
    send_frame();
    frame_buf.delete();
    add_sample(5);
    add_sample(100);
    add_sample(300);
    add_sample(250);
    send_frame();
    // peak on the near edge
    frame_buf.delete();
    add_sample(0);
    add_sample(500);
    add_sample(100);
    add_sample(50);
    send_frame();
    // peak level with its neighbour
    frame_buf.delete();
    add_sample(0);
    add_sample(10);
    add_sample(400);
    add_sample(400);
    send_frame();
    // window touching frame start
    set_window(16'd0, 16'd600, 16'd6, 16'd0, 16'd300);
    frame_buf.delete();
    add_sample(0);
    add_sample(0);
    add_sample(900);
    add_sample(0);
    send_frame();
    // equal frame start and end
    set_window(16'd600, 16'd600, 16'd6, 16'd100, 16'd300);
    frame_buf.delete();
    add_sample(1);
    add_sample(2);
    send_frame();
    // zero samples per frame
    set_window(16'd0, 16'd600, 16'd0, 16'd100, 16'd300);
    frame_buf.delete();
    add_sample(-1);
    add_sample(7);
    send_frame();
    // reversed window
    set_window(16'd0, 16'd600, 16'd6, 16'd300, 16'd100);
    frame_buf.delete();
    add_sample(3);
    add_sample(-3);
    send_frame();
  endtask

  task automatic test_far_window();
    send_gap_max = 1;
    recv_gap_max = 1;
    // window near the counter limit, then past it, frames ending early
    set_window(16'd0, 16'd3000, 16'd3000, 16'd2000, 16'd2040);
    frame_buf.delete();
    repeat (24) add_sample(int'($urandom));
    send_frame();
    set_window(16'd0, 16'd3000, 16'd3000, 16'd2000, 16'd2100);
    frame_buf.delete();
    repeat (24) add_sample(int'($urandom));
    send_frame();
  endtask

  task automatic test_backpressure();
    set_window(16'd0, 16'd600, 16'd6, 16'd100, 16'd300);
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_cycles = 1500;
    repeat (8) begin
      build_frame(SHAPE_GOOD, 60, $urandom_range(0, 1));
      send_frame();
    end
    wait_idle();
  endtask

  task automatic pick_normal_window();
    int n, span, l, h, st, en, fr_mm, to_mm;
    bit rev;
    n = $urandom_range(8, 48);
    span = $urandom_range(n, 30000);
    rev = ($urandom_range(0, 3) == 0);
    l = $urandom_range(1, n / 3);
    h = $urandom_range(l + 3, n - 3);
    if (rev) begin
      st = $urandom_range(span, 65535);
      en = st - span;
      fr_mm = st - l * span / n;
      to_mm = st - h * span / n;
    end else begin
      st = $urandom_range(0, 65535 - span);
      en = st + span;
      fr_mm = st + l * span / n;
      to_mm = st + h * span / n;
    end
    set_window(st[15:0], en[15:0], n[15:0], fr_mm[15:0], to_mm[15:0]);
  endtask

  task automatic pick_extreme_window(int which);
    case (which)
      0: set_window(16'd0, 16'hFFFF, 16'hFFFF, 16'd32, 16'd192);
      1: set_window(16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd0);
      default: set_window(16'd0, 16'd20480, 16'h0800, 16'd20, 16'd200);
    endcase
  endtask

  task automatic test_random();
    int ph, r, phase_start;
    frame_shape_e shape;
    ph = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (ph % 5)
        0: pick_extreme_window((ph / 5) % 3);
        4: set_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
        default: pick_normal_window();
      endcase
      send_gap_max = pick_gap();
      recv_gap_max = pick_gap();
      phase_start = random_items;
      while (random_items - phase_start < 80) begin
        r = $urandom_range(0, 19);
        if (r < 14) shape = SHAPE_GOOD;
        else if (r == 14) shape = SHAPE_PLATEAU;
        else if (r == 15) shape = SHAPE_BOUNDARY;
        else if (r == 16) shape = SHAPE_SHORT;
        else shape = SHAPE_NOISE;
        build_frame(shape, 60, $urandom_range(0, 3));
        random_items += frame_buf.size();
        send_frame();
      end
      ph++;
    end
  endtask

  task automatic report(string field, longint want, longint got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result item, expected none, got %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (want.found) peaks_seen++;
    if (got.found !== want.found) report("found", want.found, got.found);
    if (got.peak_index !== want.peak_index)
      report("peak_index", want.peak_index, got.peak_index);
    if (got.peak_distance_mm !== want.peak_distance_mm)
      report("peak_distance_mm", want.peak_distance_mm, got.peak_distance_mm);
    if (got.peak_power !== want.peak_power)
      report("peak_power", want.peak_power, got.peak_power);
  endtask

  // result side
  initial begin
    int gap, held;
    pop = 1'b0;
    wait (!rst);
    forever begin
      if (hold_cycles > 0) begin
        held = hold_cycles;
        hold_cycles = 0;
        repeat (held) begin
          @(negedge clk);
          pop <= 1'b0;
        end
      end
      gap = $urandom_range(0, recv_gap_max);
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result(result);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_start = RST_FRAME_START;
    reg_end = RST_FRAME_END;
    reg_n = RST_SAMPLES;
    reg_from = RST_SEARCH_FROM;
    reg_to = RST_SEARCH_TO;
    clear_tracking();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_far_window();
    test_backpressure();
    test_random();

    wait_idle();
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d result items never arrived", $time, pending_results.size());
    end
    $display("%0d samples in %0d frames over %0d window settings, %0d results, %0d peaks",
             items_sent, frames_sent, settings_count, results_seen, peaks_seen);
    $display("input held off for %0d cycles, %0d cycles in all", stall_cycles, cycle_count);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wpi_pkg.sv
rtl/core/wpi_div.sv
rtl/core/wpi_bounds.sv
rtl/core/wpi_front.sv
rtl/core/wpi_queue.sv
rtl/core/wpi_back.sv
rtl/core/windowed_peak_interpolator.sv
tb/tb_windowed_peak_interpolator.sv
